/* design/wed_pkg.sv */
package wed_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    localparam int SYM_W  = 8;
    localparam int COST_W = 8;
    localparam int DIST_W = 16;
    localparam int FLAG_W = 4;
    localparam int CFG_W  = 2;

    localparam logic [DIST_W-1:0] DIST_MAX   = '1;
    localparam logic [COST_W-1:0] COST_RESET = 8'd16;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_PATTERN = 2'd1;
    localparam logic [1:0] ACT_TEXT    = 2'd2;

    localparam logic [CFG_W-1:0] CFG_SUB = 2'd0;
    localparam logic [CFG_W-1:0] CFG_DEL = 2'd1;
    localparam logic [CFG_W-1:0] CFG_INS = 2'd2;

    localparam int FLAG_MATCH = 0;
    localparam int FLAG_SUB   = 1;
    localparam int FLAG_INS   = 2;
    localparam int FLAG_DEL   = 3;

    typedef struct packed {
        logic [COST_W-1:0] sub;
        logic [COST_W-1:0] del;
        logic [COST_W-1:0] ins;
    } costs_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] diag;
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] border;
        logic [FLAG_W-1:0] flags;
    } token_t;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    endfunction

endpackage

/* design/wed_item_if.sv */
interface wed_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] symbol;

    modport source (output valid, action, symbol, input ready);
    modport sink (input valid, action, symbol, output ready);
endinterface

/* design/wed_result_if.sv */
interface wed_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance;
    logic [3:0]  step_flags;
    logic [15:0] text_position;
    logic        pattern_overflowed;

    modport source (output valid, distance, step_flags, text_position, pattern_overflowed,
                    input ready);
    modport sink (input valid, distance, step_flags, text_position, pattern_overflowed,
                  output ready);
endinterface

/* design/wed_cell.sv */
module wed_cell
    import wed_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             active,
    input  logic             pat_we,
    input  logic [SYM_W-1:0] pat_sym,
    input  logic [SYM_W-1:0] text_sym,
    input  logic             first_row,
    input  costs_t           costs,
    input  token_t           tok_in,
    output token_t           tok_out
);

    logic [SYM_W-1:0]  pat_reg;
    logic [DIST_W-1:0] prev_reg;
    logic              valid_reg;
    token_t            payload_reg;

    logic              fire;
    logic              same;
    logic [DIST_W-1:0] border_next;
    logic [DIST_W-1:0] up;
    logic [DIST_W-1:0] c_sub;
    logic [DIST_W-1:0] c_ins;
    logic [DIST_W-1:0] c_del;
    logic [DIST_W-1:0] best;
    logic [FLAG_W-1:0] flags;
    token_t            tok_next;

    assign fire = active && tok_in.valid;

    always_comb
    begin
        border_next = sat_add(tok_in.border, {{(DIST_W-COST_W){1'b0}}, costs.del});
        up          = first_row ? border_next : prev_reg;
        c_sub       = sat_add(tok_in.diag, {{(DIST_W-COST_W){1'b0}}, costs.sub});
        c_ins       = sat_add(up, {{(DIST_W-COST_W){1'b0}}, costs.ins});
        c_del       = sat_add(tok_in.left, {{(DIST_W-COST_W){1'b0}}, costs.del});
        same        = (pat_reg == text_sym);

        best = c_sub;
        if (same && (tok_in.diag < best))
        begin
            best = tok_in.diag;
        end
        if (c_ins < best)
        begin
            best = c_ins;
        end
        if (c_del < best)
        begin
            best = c_del;
        end

        flags             = '0;
        flags[FLAG_MATCH] = same && (tok_in.diag == best);
        flags[FLAG_SUB]   = (c_sub == best);
        flags[FLAG_INS]   = (c_ins == best);
        flags[FLAG_DEL]   = (c_del == best);

        tok_next.valid  = 1'b1;
        tok_next.diag   = up;
        tok_next.left   = best;
        tok_next.border = border_next;
        tok_next.flags  = flags;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_reg <= pat_sym;
        end
        if (fire)
        begin
            prev_reg    <= best;
            payload_reg <= tok_next;
        end
    end

    always_comb
    begin
        tok_out       = payload_reg;
        tok_out.valid = valid_reg;
    end

endmodule

/* design/weighted_edit_distance_row.sv */
// Weighted edit distance between a stored pattern of up to MAX_PATTERN bytes and a streamed
// text, one matrix row per text word. Each pattern symbol lives in one cell of a chain that
// also holds that column of the previous row; a text word enters the chain as a token that
// moves one cell per cycle. A clear, a pattern append or an unused action gives no result.
// A text word passes through the accepting state, the two steps of the shared border
// multiplier, the launch step, the walk down the chain (none for an empty pattern) and the
// load of the output register; the next word is taken once the result is in that register.
// Weights are unsigned Q4.4, distances unsigned Q12.4; distances saturate at raw 65535.
module weighted_edit_distance_row
    import wed_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_index,
    input  logic [COST_W-1:0]  cfg_data,
    wed_item_if.sink           item,
    wed_result_if.source       result
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BDIAG  = 3'd1;
    localparam logic [2:0] S_BLEFT  = 3'd2;
    localparam logic [2:0] S_LAUNCH = 3'd3;
    localparam logic [2:0] S_RUN    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    costs_t            costs_reg, costs_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [DIST_W-1:0] row_count_reg, row_count_next;
    logic              ovf_reg, ovf_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic              first_reg, first_next;
    logic [DIST_W-1:0] diag_reg, diag_next;
    logic [DIST_W-1:0] left_reg, left_next;
    logic [DIST_W-1:0] res_dist_reg, res_dist_next;
    logic [FLAG_W-1:0] res_flags_reg, res_flags_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;
    logic [FLAG_W-1:0] out_flags_reg, out_flags_next;
    logic [DIST_W-1:0] out_pos_reg, out_pos_next;
    logic              out_ovf_reg, out_ovf_next;

    logic                       acc;
    logic                       append_ok;
    logic [DIST_W-1:0]          row_new;
    logic [DIST_W-1:0]          mul_k;
    logic [DIST_W+COST_W-1:0]   product;
    logic [DIST_W-1:0]          border_val;
    logic [LEN_W-1:0]           last_idx;
    token_t                     tok_launch;
    token_t                     tok_last;
    token_t                     tok_chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0]     chain_valid;

    assign acc        = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign append_ok  = acc && (item.action == ACT_PATTERN) && (row_count_reg == '0)
                        && (len_reg != LEN_W'(MAX_PATTERN));

    assign row_new    = (row_count_reg == DIST_MAX) ? row_count_reg : row_count_reg + 1'b1;
    assign mul_k      = (state_reg == S_BLEFT) ? row_new : row_count_reg;
    assign product    = mul_k * costs_reg.del;
    assign border_val = (|product[DIST_W+COST_W-1:DIST_W]) ? DIST_MAX : product[DIST_W-1:0];

    always_comb
    begin
        tok_launch.valid  = (state_reg == S_LAUNCH) && (len_reg != '0);
        tok_launch.diag   = diag_reg;
        tok_launch.left   = left_reg;
        tok_launch.border = '0;
        tok_launch.flags  = '0;
    end

    assign tok_chain[0] = tok_launch;

    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN; j++)
        begin : g_cell
            wed_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .active    (LEN_W'(j) < len_reg),
                .pat_we    (append_ok && (len_reg == LEN_W'(j))),
                .pat_sym   (item.symbol),
                .text_sym  (sym_reg),
                .first_row (first_reg),
                .costs     (costs_reg),
                .tok_in    (tok_chain[j]),
                .tok_out   (tok_chain[j+1])
            );
            assign chain_valid[j] = tok_chain[j+1].valid;
        end
    endgenerate

    assign last_idx = len_reg - 1'b1;
    assign tok_last = tok_chain[{1'b0, last_idx[IDX_W-1:0]} + 1'b1];

    always_comb
    begin
        state_next     = state_reg;
        costs_next     = costs_reg;
        len_next       = len_reg;
        row_count_next = row_count_reg;
        ovf_next       = ovf_reg;
        sym_next       = sym_reg;
        first_next     = first_reg;
        diag_next      = diag_reg;
        left_next      = left_reg;
        res_dist_next  = res_dist_reg;
        res_flags_next = res_flags_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_dist_next  = out_dist_reg;
        out_flags_next = out_flags_reg;
        out_pos_next   = out_pos_reg;
        out_ovf_next   = out_ovf_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SUB: costs_next.sub = cfg_data;
                CFG_DEL: costs_next.del = cfg_data;
                CFG_INS: costs_next.ins = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (item.action)
                        ACT_CLEAR:
                        begin
                            len_next       = '0;
                            row_count_next = '0;
                            ovf_next       = 1'b0;
                        end
                        ACT_PATTERN:
                        begin
                            if (row_count_reg == '0)
                            begin
                                if (len_reg == LEN_W'(MAX_PATTERN))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    len_next = len_reg + 1'b1;
                                end
                            end
                        end
                        ACT_TEXT:
                        begin
                            sym_next   = item.symbol;
                            first_next = (row_count_reg == '0);
                            state_next = S_BDIAG;
                        end
                        default: ;
                    endcase
                end
            end
            S_BDIAG:
            begin
                diag_next  = border_val;
                state_next = S_BLEFT;
            end
            S_BLEFT:
            begin
                left_next  = border_val;
                state_next = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                row_count_next = row_new;
                if (len_reg == '0)
                begin
                    res_dist_next  = left_reg;
                    res_flags_next = '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (tok_last.valid)
                begin
                    res_dist_next  = tok_last.left;
                    res_flags_next = tok_last.flags;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = res_dist_reg;
                    out_flags_next = res_flags_reg;
                    out_pos_next   = row_count_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            costs_reg     <= '{sub: COST_RESET, del: COST_RESET, ins: COST_RESET};
            len_reg       <= '0;
            row_count_reg <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            costs_reg     <= costs_next;
            len_reg       <= len_next;
            row_count_reg <= row_count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        first_reg     <= first_next;
        diag_reg      <= diag_next;
        left_reg      <= left_next;
        res_dist_reg  <= res_dist_next;
        res_flags_reg <= res_flags_next;
        out_dist_reg  <= out_dist_next;
        out_flags_reg <= out_flags_next;
        out_pos_reg   <= out_pos_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign result.valid              = out_valid_reg;
    assign result.distance           = out_dist_reg;
    assign result.step_flags         = out_flags_reg;
    assign result.text_position      = out_pos_reg;
    assign result.pattern_overflowed = out_ovf_reg;

    // Only one row token may travel the chain at a time.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one token in the cell chain");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_run_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (row_count_reg != '0) && (len_reg != '0))
        else $error("chain walk without a counted row or a pattern");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (item.action == ACT_CLEAR)) |=> (len_reg == '0) && (row_count_reg == '0)
            && !ovf_reg)
        else $error("clear did not empty pattern and text");

    a_token_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (|chain_valid) |-> (state_reg == S_RUN) || (state_reg == S_DONE)
            || (state_reg == S_IDLE) || (state_reg == S_BDIAG))
        else $error("row token alive outside a text word");

endmodule
